FILE: src/act_pkg.sv
// shared types, token kinds and character codes for the assembly character tokenizer
// depends on nothing; imported by every module under src
package act_pkg;

    // position and length limits
    localparam int MAX_LINE    = 1024;
    localparam int COL_CAP_INT = ((MAX_LINE - 1) < 1023) ? (MAX_LINE - 1) : 1023;
    localparam logic [9:0]  COL_CAP  = 10'(COL_CAP_INT);
    localparam logic [9:0]  LEN_CAP  = 10'd1023;
    localparam logic [15:0] LINE_CAP = 16'hFFFF;

    // record queue between scanner and output stage, depth a power of two
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    // token kinds
    localparam logic [3:0] K_MINUS   = 4'd0;
    localparam logic [3:0] K_PLUS    = 4'd1;
    localparam logic [3:0] K_DOLLAR  = 4'd2;
    localparam logic [3:0] K_LPAREN  = 4'd3;
    localparam logic [3:0] K_RPAREN  = 4'd4;
    localparam logic [3:0] K_STOP    = 4'd5;
    localparam logic [3:0] K_COLON   = 4'd6;
    localparam logic [3:0] K_COMMA   = 4'd7;
    localparam logic [3:0] K_COMMENT = 4'd8;
    localparam logic [3:0] K_STRING  = 4'd9;
    localparam logic [3:0] K_CHAR    = 4'd10;
    localparam logic [3:0] K_IDENT   = 4'd11;
    localparam logic [3:0] K_DEC     = 4'd12;
    localparam logic [3:0] K_HEX     = 4'd13;
    localparam logic [3:0] K_END     = 4'd14;
    localparam logic [3:0] K_ERROR   = 4'd15;

    // input item kinds
    localparam logic IN_CHAR = 1'b0;
    localparam logic IN_EOI  = 1'b1;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STOP   = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] line;
        logic [9:0]  column;
        logic [9:0]  value_length;
        logic [7:0]  char_value;
        logic        last;
    } out_item_t;

    // what one input item leaves for the back end: one or two tokens
    typedef struct packed {
        logic      two;
        out_item_t tok0;
        out_item_t tok1;
    } tok_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    function automatic out_item_t mk_tok(logic [3:0] k, logic [15:0] ln, logic [9:0] col,
                                         logic [9:0] len, logic [7:0] cv);
        out_item_t t;
        t.token_kind   = k;
        t.line         = ln;
        t.column       = col;
        t.value_length = len;
        t.char_value   = cv;
        t.last         = 1'b0;
        return t;
    endfunction

endpackage

FILE: src/act_front.sv
// scanner front end: classifies each source byte and updates the scan state
// depends on act_pkg
module act_front import act_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    input  logic     drop_comments,
    output logic     rec_valid,
    output tok_rec_t rec
);

    typedef enum logic [3:0] {
        M_IDLE, M_SKIP, M_COMMENT, M_STRING, M_CHARQ, M_IDENT, M_ZERO, M_DEC, M_HEX
    } mode_t;

    mode_t       mode_reg,  mode_next;
    logic [15:0] line_reg,  line_next;
    logic [9:0]  col_reg,   col_next;
    logic [9:0]  start_reg, start_next;
    logic [9:0]  len_reg,   len_next;

    logic        a_vld, b_vld, taken;
    out_item_t   a_tok, b_tok;
    logic [7:0]  c;
    logic [9:0]  len_grow;
    logic [15:0] end_line;

    function automatic logic is_letter(logic [7:0] x);
        return (x >= CH_LO_A && x <= CH_LO_Z) || (x >= CH_UP_A && x <= CH_UP_Z);
    endfunction

    function automatic logic is_digit(logic [7:0] x);
        return x >= CH_ZERO && x <= CH_NINE;
    endfunction

    function automatic logic is_hex(logic [7:0] x);
        return is_digit(x) || (x >= CH_LO_A && x <= CH_LO_F) || (x >= CH_UP_A && x <= CH_UP_F);
    endfunction

    assign c        = item.ch;
    assign len_grow = (len_reg < LEN_CAP) ? len_reg + 10'd1 : len_reg;
    assign end_line = (col_reg != 10'd0 && line_reg < LINE_CAP) ? line_reg + 16'd1 : line_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        start_next = start_reg;
        len_next   = len_reg;
        taken      = 1'b0;
        b_vld      = 1'b0;
        b_tok      = mk_tok(K_ERROR, line_reg, col_reg, 10'd1, c);

        // pending token closed by this byte or by end of input
        a_vld = 1'b0;
        a_tok = mk_tok(K_IDENT, line_reg, start_reg, len_reg, 8'd0);
        case (mode_reg)
            M_COMMENT:
            begin
                a_vld = !drop_comments;
                a_tok.token_kind = K_COMMENT;
            end
            M_STRING: begin a_vld = 1'b1; a_tok.token_kind = K_STRING; end
            M_IDENT:  begin a_vld = 1'b1; a_tok.token_kind = K_IDENT;  end
            M_ZERO, M_DEC: begin a_vld = 1'b1; a_tok.token_kind = K_DEC; end
            M_HEX:    begin a_vld = 1'b1; a_tok.token_kind = K_HEX;    end
            default:  a_vld = 1'b0;
        endcase

        if (item.kind == IN_EOI)
        begin
            if (mode_reg == M_CHARQ)
            begin
                a_vld = 1'b1;
                a_tok = mk_tok(K_CHAR, line_reg, start_reg, 10'd0, 8'd0);
            end
            b_vld      = 1'b1;
            b_tok      = mk_tok(K_END, end_line, 10'd0, 10'd0, 8'd0);
            mode_next  = M_IDLE;
            line_next  = '0;
            col_next   = '0;
            start_next = '0;
            len_next   = '0;
        end
        else
        begin
            case (mode_reg)
                M_SKIP:
                begin
                    a_vld = 1'b0;
                    if (c != CH_LF) taken = 1'b1;
                    else mode_next = M_IDLE;
                end
                M_CHARQ:
                begin
                    a_vld = 1'b1;
                    a_tok = mk_tok(K_CHAR, line_reg, start_reg,
                                   (c != CH_NUL) ? 10'd1 : 10'd0, c);
                    mode_next = (c == CH_NUL) ? M_SKIP : M_IDLE;
                    taken = 1'b1;
                end
                M_STRING:
                begin
                    if (c == CH_DQUOTE)
                    begin
                        mode_next = M_IDLE;
                        taken = 1'b1;
                    end
                    else if (c == CH_LF || c == CH_NUL)
                        mode_next = M_IDLE;
                    else
                    begin
                        a_vld = 1'b0;
                        len_next = len_grow;
                        taken = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (c == CH_LF || c == CH_NUL)
                        mode_next = M_IDLE;
                    else
                    begin
                        a_vld = 1'b0;
                        len_next = len_grow;
                        taken = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    if (is_letter(c) || is_digit(c) || c == CH_USCORE)
                    begin
                        a_vld = 1'b0;
                        len_next = len_grow;
                        taken = 1'b1;
                    end
                    else
                        mode_next = M_IDLE;
                end
                M_ZERO:
                begin
                    if (c == CH_LO_X || c == CH_UP_X)
                    begin
                        a_vld = 1'b0;
                        mode_next = M_HEX;
                        len_next = 10'd0;
                        taken = 1'b1;
                    end
                    else if (is_hex(c))
                    begin
                        a_vld = 1'b0;
                        mode_next = M_DEC;
                        len_next = len_grow;
                        taken = 1'b1;
                    end
                    else
                        mode_next = M_IDLE;
                end
                M_DEC, M_HEX:
                begin
                    if (is_hex(c))
                    begin
                        a_vld = 1'b0;
                        len_next = len_grow;
                        taken = 1'b1;
                    end
                    else
                        mode_next = M_IDLE;
                end
                default: mode_next = M_IDLE;
            endcase

            // a byte that no pending token took starts afresh
            if (!taken)
            begin
                b_tok = mk_tok(K_ERROR, line_reg, col_reg, 10'd1, 8'd0);
                case (c) inside
                    CH_SPACE, CH_TAB, CH_CR, CH_LF: ;
                    CH_NUL: mode_next = M_SKIP;
                    CH_MINUS:  begin b_vld = 1'b1; b_tok.token_kind = K_MINUS;  end
                    CH_PLUS:   begin b_vld = 1'b1; b_tok.token_kind = K_PLUS;   end
                    CH_DOLLAR: begin b_vld = 1'b1; b_tok.token_kind = K_DOLLAR; end
                    CH_LPAREN: begin b_vld = 1'b1; b_tok.token_kind = K_LPAREN; end
                    CH_RPAREN: begin b_vld = 1'b1; b_tok.token_kind = K_RPAREN; end
                    CH_STOP:   begin b_vld = 1'b1; b_tok.token_kind = K_STOP;   end
                    CH_COLON:  begin b_vld = 1'b1; b_tok.token_kind = K_COLON;  end
                    CH_COMMA:  begin b_vld = 1'b1; b_tok.token_kind = K_COMMA;  end
                    CH_HASH:
                    begin
                        mode_next = M_COMMENT; start_next = col_reg; len_next = 10'd1;
                    end
                    CH_DQUOTE:
                    begin
                        mode_next = M_STRING; start_next = col_reg; len_next = 10'd0;
                    end
                    CH_SQUOTE:
                    begin
                        mode_next = M_CHARQ; start_next = col_reg; len_next = 10'd0;
                    end
                    CH_ZERO:
                    begin
                        mode_next = M_ZERO; start_next = col_reg; len_next = 10'd1;
                    end
                    [CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_USCORE:
                    begin
                        mode_next = M_IDENT; start_next = col_reg; len_next = 10'd1;
                    end
                    [CH_ONE:CH_NINE]:
                    begin
                        mode_next = M_DEC; start_next = col_reg; len_next = 10'd1;
                    end
                    default:
                    begin
                        b_vld = 1'b1;
                        b_tok.char_value = c;
                    end
                endcase
            end

            // position bookkeeping, both counts saturate
            if (c == CH_LF)
            begin
                line_next = (line_reg < LINE_CAP) ? line_reg + 16'd1 : line_reg;
                col_next  = 10'd0;
            end
            else if (col_reg < COL_CAP)
                col_next = col_reg + 10'd1;
        end
    end

    always_comb
    begin
        rec_valid = a_vld || b_vld;
        rec.two   = a_vld && b_vld;
        rec.tok0  = a_vld ? a_tok : b_tok;
        rec.tok1  = b_tok;
        rec.tok0.last = !(a_vld && b_vld);
        rec.tok1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            line_reg  <= '0;
            col_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

endmodule

FILE: src/act_queue.sv
// four-entry queue of token records between scanner and output stage
// depends on act_pkg
module act_queue import act_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tok_rec_t  push_data,
    input  logic      pop,
    output tok_rec_t  rd_data,
    output q_status_t status
);

    tok_rec_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign status.full  = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + (Q_PTR_W+1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (Q_PTR_W+1)'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

FILE: src/act_back.sv
// output stage: hands out the one or two tokens of the head record, one beat each
// depends on act_pkg
module act_back import act_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_rec_t  head,
    input  q_status_t q_status,
    input  logic      pop,
    output logic      q_pop,
    output logic      empty,
    output out_item_t result
);

    logic sel_reg, sel_next;
    logic beat;

    assign empty  = q_status.empty;
    assign beat   = pop && !q_status.empty;
    assign result = sel_reg ? head.tok1 : head.tok0;
    // record retires on its last token
    assign q_pop  = beat && (sel_reg || !head.two);

    always_comb
    begin
        sel_next = sel_reg;
        if (beat)
            sel_next = !sel_reg && head.two;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

endmodule

FILE: src/assembly_char_tokenizer.sv
// top level of the assembly character tokenizer: scanner, record queue, output stage
// depends on act_pkg, act_front, act_queue, act_back
//
//  channel  | handshake             | beat carries
//  ---------+-----------------------+-----------------------------------------
//  input    | push / full           | item: kind, ch (one byte or end mark)
//  result   | empty / pop           | result: kind, line, column, length, char
//  config   | cfg_valid / cfg_ready | cfg_data: drop_comments
//
// one input beat per cycle while full is low; the scanner updates its state in the accepting cycle
// and files the one or two tokens that a byte yields as one record in a four-entry queue
// a record of two tokens takes two result beats; the result side sets the rate
// only when inputs average more than one token per byte
// a record reaches the result port once the records ahead of it are read; reset clears scan state,
// queue and the drop_comments register; cfg_ready is always high
// full rises only when four records wait unread
module assembly_char_tokenizer import act_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  in_item_t  item,
    output logic      empty,
    input  logic      pop,
    output out_item_t result,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data
);

    logic      drop_reg;
    logic      accept;
    logic      rec_valid;
    tok_rec_t  rec;
    tok_rec_t  head;
    q_status_t q_status;
    logic      q_pop;

    assign cfg_ready = 1'b1;
    assign full      = q_status.full;
    assign accept    = push && !q_status.full;

    // drop_comments register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drop_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            drop_reg <= cfg_data;
    end

    // scanner: classifies bytes and tracks line, column and pending token
    act_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .item          (item),
        .drop_comments (drop_reg),
        .rec_valid     (rec_valid),
        .rec           (rec)
    );

    // decoupling queue, a record only when the byte produced tokens
    act_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && rec_valid),
        .push_data (rec),
        .pop       (q_pop),
        .rd_data   (head),
        .status    (q_status)
    );

    // output stage
    act_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .q_pop    (q_pop),
        .empty    (empty),
        .result   (result)
    );

    // a non-final token is always followed by its partner
    a_partner_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !result.last) |=> !empty)
        else $error("second token of a record missing");

    // the end token closes its input's results and sits at column zero
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.token_kind == K_END) |->
            (result.last && result.column == 10'd0 && result.value_length == 10'd0))
        else $error("malformed end token");

    // back pressure only while results wait
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full asserted with no results waiting");

endmodule
